[rtl/jcsl_pkg.sv]
// Shared types and constants of the joint command slew limiter.
package jcsl_pkg;

  localparam int unsigned JOINT_COUNT = 8;
  localparam int unsigned JOINT_W     = $clog2(JOINT_COUNT);
  localparam int unsigned POS_W       = 24;
  localparam int unsigned STEP_W      = 18;

  // Wrap arithmetic: x = target - prev + pi + 42 * 2pi is always in [0, 2^26)
  localparam int unsigned WRAP_W      = POS_W + 2;
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned PROD_W      = WRAP_W + RECIP_W;
  localparam int unsigned QUO_W       = 7;
  localparam int unsigned REM_W       = 20;
  localparam int unsigned DELTA_W     = POS_W + 2;
  localparam int unsigned STEP_D_W    = STEP_W + 1;
  localparam int unsigned SUM_W       = POS_W + 2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [STEP_W-1:0]       MAX_STEP_RESET = STEP_W'(6554);
  localparam logic [REM_W-1:0]        Q_PI           = REM_W'(205887);
  localparam logic [REM_W-1:0]        Q_TWO_PI       = REM_W'(411775);
  localparam logic signed [POS_W:0]   Q_CONT_SPAN    = (POS_W+1)'(411710);
  localparam logic [WRAP_W-1:0]       WRAP_OFS       = WRAP_W'(42 * 411775 + 205887);
  // floor(2^32 / 2pi); quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0]      RECIP_M        = RECIP_W'(10430);

  typedef enum logic [0:0] {
    OP_CONFIG = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [JOINT_W-1:0]      joint_index;
    logic signed [POS_W-1:0] target_position;
    logic signed [POS_W-1:0] limit_lower;
    logic signed [POS_W-1:0] limit_upper;
    logic                    limits_unbounded;
    logic                    last_joint;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]      out_joint;
    logic signed [POS_W-1:0] command;
    logic                    out_last;
  } out_item_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    op_e                     op;
    logic [JOINT_W-1:0]      joint;
    logic                    last;
    logic                    cont;
    logic signed [POS_W-1:0] target;
    logic [WRAP_W-1:0]       tgt_off;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
  } entry_t;

endpackage

[rtl/joint_command_slew_limiter_core.sv]
// Joint command slew limiter: top level with max step register.
// Path: a sample is written into the queue, then passes from the queue head through the
//   pipeline stages, the last one loading the output register; configure items give no result.
// Throughput: one item per cycle while the output is not stalled; a sample waits while one
//   of the 4 samples ahead of it is for the same joint, until that one writes its command back.
// Reset: history off, commands and limits zero, all joints continuous, max step 6554.
module joint_command_slew_limiter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  jcsl_pkg::in_item_t          in_data_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output jcsl_pkg::out_item_t         out_data_o,
  // max step register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [jcsl_pkg::STEP_W-1:0] cfg_data_i
);
  import jcsl_pkg::*;

  logic [STEP_W-1:0] max_step_q;
  entry_t            push_entry, head_entry;
  logic              head_valid, head_ready;

  // register write always completes in the cycle it is offered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MAX_STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_step_q <= cfg_data_i;
    end
  end

  // front end: per-item classification (continuous span check, wrap offset)
  jcsl_front u_front (
    .in_data_i (in_data_i),
    .entry_o   (push_entry)
  );

  // queue decouples the input transfer from pipeline stalls
  jcsl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (push_entry),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head_entry)
  );

  // back end: limit tables and history updated at issue, previous commands at write-back; the
  // command loop per joint closes through the same-joint hazard check
  jcsl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_step_i   (max_step_q),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_data_i  (head_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[rtl/jcsl_front.sv]
// Front end: classifies an incoming item and precomputes per-item terms.
module jcsl_front (
  input  jcsl_pkg::in_item_t in_data_i,
  output jcsl_pkg::entry_t   entry_o
);
  import jcsl_pkg::*;

  logic signed [POS_W:0] span;
  logic                  span_ok;

  assign span    = (POS_W+1)'(in_data_i.limit_upper) - (POS_W+1)'(in_data_i.limit_lower);
  assign span_ok = (span >= Q_CONT_SPAN);

  always_comb begin
    entry_o.op      = in_data_i.op;
    entry_o.joint   = in_data_i.joint_index;
    entry_o.last    = in_data_i.last_joint;
    entry_o.cont    = in_data_i.limits_unbounded | span_ok;
    entry_o.target  = in_data_i.target_position;
    // target + pi + 42*2pi; the back end subtracts the previous command
    entry_o.tgt_off = WRAP_W'(in_data_i.target_position) + WRAP_OFS;
    entry_o.lo      = in_data_i.limit_lower;
    entry_o.hi      = in_data_i.limit_upper;
  end

endmodule

[rtl/jcsl_queue.sv]
// Small FIFO between the front end and the execution pipeline.
module jcsl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  jcsl_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output jcsl_pkg::entry_t pop_data_o
);
  import jcsl_pkg::*;

  entry_t              fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = fifo_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/jcsl_back.sv]
// Execution pipeline: joint tables, wrapped delta, slew clamp, limits, output register.
module jcsl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [jcsl_pkg::STEP_W-1:0] max_step_i,
  input  logic                        head_valid_i,
  output logic                        head_ready_o,
  input  jcsl_pkg::entry_t            head_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output jcsl_pkg::out_item_t         out_data_o
);
  import jcsl_pkg::*;

  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic                    last;
    logic                    pass;
    logic                    cont;
    logic                    lim_en;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] base;
    logic signed [POS_W:0]   raw;
  } ctx_t;

  // joint state
  logic signed [POS_W-1:0] prev_q [JOINT_COUNT];
  logic signed [POS_W-1:0] lo_q   [JOINT_COUNT];
  logic signed [POS_W-1:0] hi_q   [JOINT_COUNT];
  logic [JOINT_COUNT-1:0]  cont_q;
  logic                    hist_q;

  // pipeline
  logic                    adv, hazard, issue, is_cfg;
  logic [JOINT_W-1:0]      hj;
  logic signed [POS_W-1:0] prev_rd;
  ctx_t                    ctx0, ctx1_q, ctx2_q, ctx3_q, ctx4_q;
  logic                    vld1_q, vld2_q, vld3_q, vld4_q;
  logic [WRAP_W-1:0]       x0, x1_q, x2_q;
  logic [PROD_W-1:0]       prod;
  logic [QUO_W-1:0]        q2_q;
  logic [WRAP_W-1:0]       qd;
  logic [REM_W-1:0]        r3_q, r_fix;
  logic signed [REM_W:0]   wrapped;
  logic signed [DELTA_W-1:0] delta, step_s;
  logic signed [STEP_D_W-1:0] d_next, d4_q;
  logic signed [SUM_W-1:0] sum, lim, sat;
  logic signed [POS_W-1:0] cmd;
  logic                    out_valid_q;
  out_item_t               out_q;

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  assign adv    = ~out_valid_q | out_ready_i;
  assign hj     = head_data_i.joint;
  assign is_cfg = (head_data_i.op == OP_CONFIG);

  // a sample waits while an older sample of the same joint has not written back
  assign hazard = (vld1_q & (ctx1_q.joint == hj)) | (vld2_q & (ctx2_q.joint == hj))
                | (vld3_q & (ctx3_q.joint == hj)) | (vld4_q & (ctx4_q.joint == hj));

  assign head_ready_o = adv & (is_cfg | ~hazard);
  assign issue        = head_valid_i & head_ready_o;

  // stage 0: table lookup and classification
  always_comb begin
    prev_rd     = prev_q[hj];
    ctx0.joint  = hj;
    ctx0.last   = head_data_i.last;
    ctx0.pass   = ~hist_q;
    ctx0.cont   = cont_q[hj];
    ctx0.lim_en = ~cont_q[hj] & (lo_q[hj] <= hi_q[hj]);
    ctx0.lo     = lo_q[hj];
    ctx0.hi     = hi_q[hj];
    ctx0.base   = hist_q ? prev_rd : head_data_i.target;
    ctx0.raw    = (POS_W+1)'(head_data_i.target) - (POS_W+1)'(prev_rd);
    x0          = head_data_i.tgt_off - WRAP_W'(prev_rd);
  end

  // stage 1: quotient estimate by reciprocal
  assign prod = PROD_W'(x1_q) * PROD_W'(RECIP_M);

  // stage 2: first remainder, below 2*2pi
  assign qd = WRAP_W'(q2_q) * WRAP_W'(Q_TWO_PI);

  // stage 3: final remainder, wrapped delta, slew clamp
  always_comb begin
    r_fix   = (r3_q >= Q_TWO_PI) ? r3_q - Q_TWO_PI : r3_q;
    wrapped = $signed({1'b0, r_fix}) - $signed({1'b0, Q_PI});
    delta   = ctx3_q.cont ? DELTA_W'(wrapped) : DELTA_W'(ctx3_q.raw);
    step_s  = $signed({{(DELTA_W-STEP_W){1'b0}}, max_step_i});
    if (ctx3_q.pass) begin
      d_next = '0;
    end else if (delta > step_s) begin
      d_next = STEP_D_W'(step_s);
    end else if (delta < -step_s) begin
      d_next = STEP_D_W'(-step_s);
    end else begin
      d_next = STEP_D_W'(delta);
    end
  end

  // stage 4: apply, limit, saturate
  always_comb begin
    sum = SUM_W'(ctx4_q.base) + SUM_W'(d4_q);
    lim = sum;
    if (ctx4_q.lim_en) begin
      if (sum < SUM_W'(ctx4_q.lo)) begin
        lim = SUM_W'(ctx4_q.lo);
      end else if (sum > SUM_W'(ctx4_q.hi)) begin
        lim = SUM_W'(ctx4_q.hi);
      end
    end
    if (lim > POS_MAX) begin
      sat = POS_MAX;
    end else if (lim < POS_MIN) begin
      sat = POS_MIN;
    end else begin
      sat = lim;
    end
    cmd = POS_W'(sat);
  end

  // joint tables and history flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        prev_q[i] <= '0;
        lo_q[i]   <= '0;
        hi_q[i]   <= '0;
      end
      cont_q <= '1;
      hist_q <= 1'b0;
    end else begin
      if (issue && is_cfg) begin
        lo_q[hj]   <= head_data_i.lo;
        hi_q[hj]   <= head_data_i.hi;
        cont_q[hj] <= head_data_i.cont;
        hist_q     <= 1'b0;
      end else if (issue && !hist_q && head_data_i.last) begin
        hist_q <= 1'b1;
      end
      if (adv && vld4_q) begin
        prev_q[ctx4_q.joint] <= cmd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      vld4_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld1_q      <= issue & ~is_cfg;
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      vld4_q      <= vld3_q;
      out_valid_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx1_q          <= ctx0;
      x1_q            <= x0;
      ctx2_q          <= ctx1_q;
      x2_q            <= x1_q;
      q2_q            <= prod[RECIP_SHIFT +: QUO_W];
      ctx3_q          <= ctx2_q;
      r3_q            <= REM_W'(x2_q - qd);
      ctx4_q          <= ctx3_q;
      d4_q            <= d_next;
      out_q.out_joint <= ctx4_q.joint;
      out_q.command   <= cmd;
      out_q.out_last  <= ctx4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
